// ===== rtl/gre_pkg.sv =====
// ----------------------------------------------------------------------------
// gre_pkg
// Types and constants shared by the glyph row color expander.
// ----------------------------------------------------------------------------
package gre_pkg;

	localparam int PALETTE_ENTRIES = 16;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int MAX_WORDS       = 4;
	localparam int CELL_ROW_W      = 14;   // line * height + row, at most 16096
	localparam int ROW_OFF_W       = 30;   // cell row * line bytes
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;

	typedef enum logic {
		OP_RENDER  = 1'b0,
		OP_PALETTE = 1'b1
	} gre_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PIXEL_MODE   = 3'd0,
		CFG_FRAME_BASE   = 3'd1,
		CFG_LINE_BYTES   = 3'd2,
		CFG_GLYPH_HEIGHT = 3'd3,
		CFG_FG_SHIFT     = 3'd4,
		CFG_BG_SHIFT     = 3'd5
	} gre_cfg_idx_t;

	typedef struct packed {
		gre_op_t     operation;
		logic [3:0]  palette_index;
		logic [15:0] palette_value;
		logic [15:0] char_code;
		logic [7:0]  text_column;
		logic [7:0]  text_line;
		logic [4:0]  glyph_row;
		logic [7:0]  row_bits;
	} gre_in_t;

	typedef struct packed {
		logic [31:0] write_address;
		logic [31:0] write_data;
		logic        last_word;
	} gre_out_t;

	// palette write request
	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] index;
		logic [15:0]       value;
	} gre_pal_wr_t;

	// one expanded row handed to the output stage
	typedef struct packed {
		logic [31:0]                 base_addr;
		logic [MAX_WORDS-1:0][31:0]  words;
		logic                        wide;
	} gre_row_t;

endpackage

// ===== rtl/gre_chan_if.sv =====
// ----------------------------------------------------------------------------
// gre_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface gre_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gre_palette.sv =====
// ----------------------------------------------------------------------------
// gre_palette
// 16-entry color palette: one write port, two registered read ports.
// Entries read as zero until first written.
// ----------------------------------------------------------------------------
module gre_palette import gre_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  gre_pal_wr_t       wr,
	input  logic              rd_en,
	input  logic [PAL_AW-1:0] rd_index_a,
	input  logic [PAL_AW-1:0] rd_index_b,
	output logic [15:0]       rd_data_a,
	output logic [15:0]       rd_data_b
);

	logic [15:0]                mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] written_q;
	logic [15:0]                data_a_q;
	logic [15:0]                data_b_q;
	logic                       hit_a_q;
	logic                       hit_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.index] <= wr.value;
		end
		if (rd_en) begin
			data_a_q <= mem[rd_index_a];
			data_b_q <= mem[rd_index_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_a_q   <= 1'b0;
			hit_b_q   <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.index] <= 1'b1;
			end
			if (rd_en) begin
				hit_a_q <= written_q[rd_index_a];
				hit_b_q <= written_q[rd_index_b];
			end
		end
	end

	assign rd_data_a = hit_a_q ? data_a_q : 16'd0;
	assign rd_data_b = hit_b_q ? data_b_q : 16'd0;

endmodule

// ===== rtl/gre_serializer.sv =====
// ----------------------------------------------------------------------------
// gre_serializer
// Output stage: hold one expanded row and issue its words one per cycle while out_chan is ready.
// ----------------------------------------------------------------------------
module gre_serializer import gre_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  gre_row_t      row,
	output logic          free,
	gre_chan_if.source    out_chan
);

	localparam int KW = $clog2(MAX_WORDS);

	logic                       v_q;
	logic [KW-1:0]              k_q;
	logic [31:0]                addr_q;
	logic [MAX_WORDS-1:0][31:0] words_q;
	logic                       wide_q;
	logic                       last;
	logic                       take;

	assign last = wide_q ? (k_q == KW'(MAX_WORDS - 1)) : (k_q == KW'(1));
	assign take = v_q && out_chan.ready;
	assign free = !v_q || (out_chan.ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
			k_q <= '0;
		end else if (load) begin
			v_q <= 1'b1;
			k_q <= '0;
		end else if (take) begin
			if (last) begin
				v_q <= 1'b0;
			end
			k_q <= k_q + KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_q  <= row.base_addr;
			words_q <= row.words;
			wide_q  <= row.wide;
		end else if (take) begin
			addr_q <= addr_q + 32'd4;
		end
	end

	assign out_chan.valid              = v_q;
	assign out_chan.data.write_address = addr_q;
	assign out_chan.data.write_data    = words_q[k_q];
	assign out_chan.data.last_word     = last;

endmodule

// ===== rtl/glyph_row_color_expander_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_row_color_expander_unit
// Expand one 8-pixel font row into 32-bit framebuffer write words.
// ----------------------------------------------------------------------------
//
//   channel   | dir | payload                                   | per request
//   ----------+-----+-------------------------------------------+---------------------
//   in_chan   | in  | gre_in_t: render row or palette write     | 0, 2 or 4 results
//   out_chan  | out | gre_out_t: address, data, last_word       | one framebuffer word
//   cfg_*     | in  | register index and data, write enable     | one register
//
// Flow: a render request passes two pipeline stages (cell row, line offset
// plus palette read) and is expanded into address and pixels on its way into
// the output register, where its first word shows once the row is loaded.
// The output register issues one word per cycle while out_chan is ready,
// two words a row at 8 bpp and four at 16 bpp, and loads the next row as
// the last word leaves; that port sets the rate. Palette writes produce no words.
// Reset: clears valid bits, palette written flags and registers to their
// defaults. Stalls: a busy output register holds stage 2, a full stage 2 holds
// stage 1 and a full stage 1 holds the input; empty stages keep filling.
// ----------------------------------------------------------------------------
module glyph_row_color_expander_unit import gre_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	gre_chan_if.sink              in_chan,
	gre_chan_if.source            out_chan
);

	// configuration registers
	logic        pixel_mode_q;
	logic [31:0] frame_base_q;
	logic [15:0] line_bytes_q;
	logic [5:0]  glyph_height_q;
	logic [3:0]  fg_shift_q;
	logic [3:0]  bg_shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q   <= 1'b0;
			frame_base_q   <= 32'd0;
			line_bytes_q   <= 16'd640;
			glyph_height_q <= 6'd16;
			fg_shift_q     <= 4'd8;
			bg_shift_q     <= 4'd12;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PIXEL_MODE:   pixel_mode_q   <= cfg_data[0];
				CFG_FRAME_BASE:   frame_base_q   <= cfg_data[31:0];
				CFG_LINE_BYTES:   line_bytes_q   <= cfg_data[15:0];
				CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_data[5:0];
				CFG_FG_SHIFT:     fg_shift_q     <= cfg_data[3:0];
				CFG_BG_SHIFT:     bg_shift_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage advances when its successor frees up
	logic v_s1, v_s2;
	logic en1, en2, en3;

	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_chan.ready = en1;

	// ---- stage 1: cell row index and color indices ----
	logic [CELL_ROW_W-1:0] cell_row_c;
	logic [15:0]           fg_sh_c, bg_sh_c;

	assign cell_row_c = CELL_ROW_W'(in_chan.data.text_line) * CELL_ROW_W'(glyph_height_q)
	                  + CELL_ROW_W'(in_chan.data.glyph_row);
	assign fg_sh_c = in_chan.data.char_code >> fg_shift_q;
	assign bg_sh_c = in_chan.data.char_code >> bg_shift_q;

	gre_op_t               op_s1;
	logic [3:0]            pidx_s1;
	logic [15:0]           pval_s1;
	logic [CELL_ROW_W-1:0] cell_row_s1;
	logic [7:0]            col_s1;
	logic [3:0]            fg_s1, bg_s1;
	logic [7:0]            bits_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1       <= in_chan.data.operation;
			pidx_s1     <= in_chan.data.palette_index;
			pval_s1     <= in_chan.data.palette_value;
			cell_row_s1 <= cell_row_c;
			col_s1      <= in_chan.data.text_column;
			fg_s1       <= fg_sh_c[3:0];
			bg_s1       <= bg_sh_c[3:0];
			bits_s1     <= in_chan.data.row_bits;
		end
	end

	// ---- stage 2: line offset, palette access ----
	// Palette writes land as their request leaves stage 1, so a later
	// render request always reads them.
	gre_pal_wr_t pal_wr;
	logic [15:0] pal_fg, pal_bg;

	assign pal_wr.en    = en2 && v_s1 && (op_s1 == OP_PALETTE);
	assign pal_wr.index = pidx_s1;
	assign pal_wr.value = pval_s1;

	gre_palette u_palette (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (pal_wr),
		.rd_en      (en2),
		.rd_index_a (fg_s1),
		.rd_index_b (bg_s1),
		.rd_data_a  (pal_fg),
		.rd_data_b  (pal_bg)
	);

	gre_op_t              op_s2;
	logic [ROW_OFF_W-1:0] row_off_s2;
	logic [7:0]           col_s2;
	logic [3:0]           fg_s2, bg_s2;
	logic [7:0]           bits_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2      <= op_s1;
			row_off_s2 <= ROW_OFF_W'(cell_row_s1) * ROW_OFF_W'(line_bytes_q);
			col_s2     <= col_s1;
			fg_s2      <= fg_s1;
			bg_s2      <= bg_s1;
			bits_s2    <= bits_s1;
		end
	end

	// ---- stage 3: word address and pixel expansion ----
	gre_row_t    row_c;
	logic [31:0] col_off_c;
	logic [7:0]  fg_byte, bg_byte;

	assign col_off_c = pixel_mode_q ? (32'(col_s2) << 4) : (32'(col_s2) << 3);
	assign fg_byte   = {4'd0, fg_s2};
	assign bg_byte   = {4'd0, bg_s2};

	always_comb begin
		row_c.base_addr = frame_base_q + 32'(row_off_s2) + col_off_c;
		row_c.wide      = pixel_mode_q;
		row_c.words     = '0;
		for (int k = 0; k < MAX_WORDS; k++) begin
			if (pixel_mode_q) begin
				// leftmost pixel to the low halfword
				for (int h = 0; h < 2; h++) begin
					row_c.words[k][16*h +: 16] = bits_s2[7 - 2*k - h] ? pal_fg : pal_bg;
				end
			end else if (k < 2) begin
				// leftmost pixel to the low byte
				for (int j = 0; j < 4; j++) begin
					row_c.words[k][8*j +: 8] = bits_s2[7 - 4*k - j] ? fg_byte : bg_byte;
				end
			end
		end
	end

	// drop palette writes here; only render rows reach the output stage
	logic load3;

	assign load3 = en3 && v_s2 && (op_s2 == OP_RENDER);

	gre_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load3),
		.row      (row_c),
		.free     (en3),
		.out_chan (out_chan)
	);

	// words of one row follow each other at consecutive addresses
	assert property (@(posedge clk) disable iff (!arst_n)
		out_chan.valid && out_chan.ready && !out_chan.data.last_word |=>
			out_chan.valid &&
			out_chan.data.write_address == $past(out_chan.data.write_address) + 32'd4)
		else $error("row words not at consecutive addresses");

	// a stalled stage 1 keeps its request
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en2 |=> v_s1 && $stable(cell_row_s1) && $stable(bits_s1))
		else $error("stage 1 request lost under stall");

	// no request enters while the output stage is blocked and the pipe is full
	assert property (@(posedge clk) disable iff (!arst_n)
		in_chan.ready |-> !v_s1 || !v_s2 || en3)
		else $error("input accepted into a full pipeline");

endmodule

// ===== tb/gre_word_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gre_word_checker
// Tracks the register settings and the palette, predicts the framebuffer
// words of every accepted render request and compares the delivered words.
// ----------------------------------------------------------------------------
module gre_word_checker import gre_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  gre_in_t               in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  gre_out_t              out_data,
	output int unsigned           fault_count,
	output int unsigned           words_outstanding
);

	logic        wide_pixels;
	logic [31:0] frame_base;
	logic [15:0] line_bytes;
	logic [5:0]  cell_height;
	logic [3:0]  fg_shift;
	logic [3:0]  bg_shift;
	logic [15:0] palette_copy [PALETTE_ENTRIES];
	gre_out_t    expected_words [$];

	task automatic report_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t gre_word_checker: %s", $time, what);
	endtask

	// queue the words one render request must produce, leftmost pixel lowest
	task automatic expand_glyph_row(input gre_in_t req);
		logic [3:0]  fg_idx;
		logic [3:0]  bg_idx;
		logic [31:0] row_addr;
		logic [31:0] pixels;
		logic        lit;
		int          n_words;
		int          w;
		int          p;
		gre_out_t    word;
		fg_idx   = 4'(req.char_code >> fg_shift);
		bg_idx   = 4'(req.char_code >> bg_shift);
		row_addr = frame_base
			+ (32'(req.text_line) * 32'(cell_height) + 32'(req.glyph_row)) * 32'(line_bytes)
			+ 32'(req.text_column) * (wide_pixels ? 32'd16 : 32'd8);
		n_words  = wide_pixels ? 4 : 2;
		for (w = 0; w < n_words; w++) begin
			pixels = '0;
			if (wide_pixels) begin
				for (p = 0; p < 2; p++) begin
					lit = req.row_bits[7 - (2 * w + p)];
					pixels[16 * p +: 16] = palette_copy[lit ? fg_idx : bg_idx];
				end
			end else begin
				for (p = 0; p < 4; p++) begin
					lit = req.row_bits[7 - (4 * w + p)];
					pixels[8 * p +: 8] = {4'h0, lit ? fg_idx : bg_idx};
				end
			end
			word.write_address = row_addr + 32'(4 * w);
			word.write_data    = pixels;
			word.last_word     = (w == n_words - 1);
			expected_words.push_back(word);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		gre_out_t want;
		gre_out_t seen;
		if (!arst_n) begin
			wide_pixels = 1'b0;
			frame_base  = '0;
			line_bytes  = 16'd640;
			cell_height = 6'd16;
			fg_shift    = 4'd8;
			bg_shift    = 4'd12;
			foreach (palette_copy[i])
				palette_copy[i] = '0;
			expected_words.delete();
			fault_count       = 0;
			words_outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (gre_cfg_idx_t'(cfg_index))
					CFG_PIXEL_MODE:   wide_pixels = cfg_data[0];
					CFG_FRAME_BASE:   frame_base  = cfg_data;
					CFG_LINE_BYTES:   line_bytes  = cfg_data[15:0];
					CFG_GLYPH_HEIGHT: cell_height = cfg_data[5:0];
					CFG_FG_SHIFT:     fg_shift    = cfg_data[3:0];
					CFG_BG_SHIFT:     bg_shift    = cfg_data[3:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				seen = out_data;
				if (expected_words.size() == 0) begin
					report_fault($sformatf("unexpected word addr %h data %h last %b",
						seen.write_address, seen.write_data, seen.last_word));
				end else begin
					want = expected_words.pop_front();
					if (seen.write_address !== want.write_address)
						report_fault($sformatf("write_address expected %h got %h",
							want.write_address, seen.write_address));
					if (seen.write_data !== want.write_data)
						report_fault($sformatf("write_data at %h expected %h got %h",
							want.write_address, want.write_data, seen.write_data));
					if (seen.last_word !== want.last_word)
						report_fault($sformatf("last_word at %h expected %b got %b",
							want.write_address, want.last_word, seen.last_word));
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.operation == OP_PALETTE)
					palette_copy[in_data.palette_index] = in_data.palette_value;
				else
					expand_glyph_row(in_data);
			end
			words_outstanding = expected_words.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives render and palette requests into the glyph row color expander under
// a series of register settings, with random gaps on the request side and
// random stalls on the word side; the checker beside the block judges words.
// ----------------------------------------------------------------------------
module tb_top;
	import gre_pkg::*;

	// no acceptance on either channel for this long means the block hung
	localparam int WATCHDOG_LIMIT  = 2000;
	// pipeline depth plus output register, with margin, for palette writes
	localparam int SETTLE_CYCLES   = 16;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 56;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           fault_count;
	int unsigned           words_outstanding;
	int unsigned           quiet_cycles;
	int unsigned           steady_left;
	logic [5:0]            cell_height;

	gre_chan_if #(.payload_t(gre_in_t))  in_chan ();
	gre_chan_if #(.payload_t(gre_out_t)) out_chan ();

	glyph_row_color_expander_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_chan   (in_chan),
		.out_chan  (out_chan)
	);

	gre_word_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_chan.valid),
		.in_ready          (in_chan.ready),
		.in_data           (in_chan.data),
		.out_valid         (out_chan.valid),
		.out_ready         (out_chan.ready),
		.out_data          (out_chan.data),
		.fault_count       (fault_count),
		.words_outstanding (words_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hold reset, then release it at a falling edge, away from the rising edge
	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Gap before the next request: mostly none or short, now and then long.
	// Every so often open a stretch of back-to-back requests.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			steady_left = $urandom_range(10, 30);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// Offer one request and hold it until the block takes it. Enter and leave
	// at a falling edge; valid stays high on exit so a follow-up request with
	// no gap goes out without a bubble.
	task automatic push_request(input gre_in_t req);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_chan.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_chan.data  = req;
		in_chan.valid = 1'b1;
		do
			@(posedge clk);
		while (!in_chan.ready);
		@(negedge clk);
	endtask

	// render one glyph row; the palette fields ride along as noise
	task automatic send_render(input logic [15:0] code, input logic [7:0] column,
			input logic [7:0] text_line, input logic [4:0] row, input logic [7:0] bits);
		gre_in_t req;
		req.operation     = OP_RENDER;
		req.palette_index = 4'($urandom);
		req.palette_value = 16'($urandom);
		req.char_code     = code;
		req.text_column   = column;
		req.text_line     = text_line;
		req.glyph_row     = row;
		req.row_bits      = bits;
		push_request(req);
	endtask

	// load one palette entry; the render fields ride along as noise
	task automatic send_palette(input logic [3:0] index, input logic [15:0] value);
		gre_in_t req;
		req.operation     = OP_PALETTE;
		req.palette_index = index;
		req.palette_value = value;
		req.char_code     = 16'($urandom);
		req.text_column   = 8'($urandom);
		req.text_line     = 8'($urandom);
		req.glyph_row     = 5'($urandom);
		req.row_bits      = 8'($urandom);
		push_request(req);
	endtask

	task automatic write_register(input gre_cfg_idx_t index, input logic [31:0] value);
		cfg_we    = 1'b1;
		cfg_index = index;
		cfg_data  = value;
		@(negedge clk);
	endtask

	// Drain the block, let trailing palette writes land, then load every
	// register. Enter and leave at a falling edge.
	task automatic settle_and_program(input logic mode, input logic [31:0] base,
			input logic [15:0] pitch, input logic [5:0] height,
			input logic [3:0] fg_pos, input logic [3:0] bg_pos);
		in_chan.valid = 1'b0;
		wait (words_outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_register(CFG_PIXEL_MODE, 32'(mode));
		write_register(CFG_FRAME_BASE, base);
		write_register(CFG_LINE_BYTES, 32'(pitch));
		write_register(CFG_GLYPH_HEIGHT, 32'(height));
		write_register(CFG_FG_SHIFT, 32'(fg_pos));
		write_register(CFG_BG_SHIFT, 32'(bg_pos));
		cfg_we      = 1'b0;
		cell_height = height;
	endtask

	// Word side pacing: short ready bursts broken by stalls, mostly short,
	// sometimes long, plus stretches with ready held high throughout.
	initial begin : sink_pacing
		int unsigned roll;
		out_chan.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			out_chan.ready = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 15) begin
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end else begin
				repeat ($urandom_range(1, 6)) @(negedge clk);
				out_chan.ready = 1'b0;
				roll = $urandom_range(0, 99);
				if (roll < 70)
					repeat ($urandom_range(1, 3)) @(negedge clk);
				else if (roll < 95)
					repeat ($urandom_range(4, 12)) @(negedge clk);
				else
					repeat ($urandom_range(20, 40)) @(negedge clk);
			end
		end
	end

	// Count cycles with no request or word accepted; end the run at the limit.
	initial begin : watchdog
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin : stimulus
		int unsigned  roll;
		int unsigned  row_span;
		int           phase;
		int           n;
		logic         mode;
		logic [31:0]  base;
		logic [15:0]  pitch;
		logic [5:0]   height;
		logic [4:0]   row;
		logic [7:0]   column;
		logic [7:0]   text_line;

		in_chan.valid = 1'b0;
		in_chan.data  = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_PIXEL_MODE;
		cfg_data      = '0;
		cell_height   = 6'd16;
		steady_left   = 0;
		@(posedge arst_n);
		@(negedge clk);

		// Reset settings: 8 bpp, 640 byte pitch, 16 line cells, fg at bit 8,
		// bg at bit 12. Cover empty and full rows, both corners of the text
		// grid, and a row index past the cell height.
		send_render(16'h0000, 8'd0, 8'd0, 5'd0, 8'h00);
		send_render(16'hFFFF, 8'd255, 8'd255, 5'd31, 8'hFF);
		send_render(16'hA500, 8'd1, 8'd2, 5'd15, 8'hA5);
		send_render(16'h5A00, 8'd17, 8'd9, 5'd3, 8'h5A);

		// load a few palette entries, including both ends of the table
		send_palette(4'd0, 16'hFFFF);
		send_palette(4'd15, 16'h8001);
		send_palette(4'd5, 16'h1234);
		send_palette(4'd10, 16'hEDCB);

		// 16 bpp with the base near the top so addresses wrap, widest pitch,
		// largest cell height, fg in the low nibble and bg at the top.
		settle_and_program(1'b1, 32'hFFFF_FFF0, 16'hFFFF, 6'd63, 4'd0, 4'd15);
		send_render(16'hF000, 8'd255, 8'd255, 5'd31, 8'h81);
		send_render(16'h0A05, 8'd0, 8'd0, 5'd0, 8'h7E);
		// fg points at an entry never loaded, which still reads as zero
		send_render(16'h5003, 8'd128, 8'd64, 5'd7, 8'hC3);

		// degenerate geometry: zero cell height and zero pitch
		settle_and_program(1'b0, 32'h1234_5678, 16'h0000, 6'd0, 4'd15, 4'd0);
		send_render(16'h8006, 8'd200, 8'd100, 5'd9, 8'h96);
		send_render(16'h7FFE, 8'd255, 8'd255, 5'd31, 8'h3C);

		// smallest sane geometry at 16 bpp
		settle_and_program(1'b1, 32'h0000_0000, 16'h0001, 6'd1, 4'd12, 4'd4);
		send_render(16'hF0A5, 8'd1, 8'd3, 5'd0, 8'h69);

		// Random phases: fresh settings each time, alternate pixel modes, mix
		// palette loads among render requests with random content.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			mode = phase[0];
			roll = $urandom_range(0, 9);
			base = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : 32'($urandom);
			roll = $urandom_range(0, 9);
			pitch = (roll == 0) ? 16'd0 : (roll == 1) ? 16'd1 : (roll == 2) ? 16'hFFFF
				: 16'($urandom_range(1, 65535));
			roll = $urandom_range(0, 9);
			height = (roll == 0) ? 6'd0 : (roll == 1) ? 6'd63 : (roll == 2) ? 6'd32
				: 6'($urandom_range(1, 32));
			settle_and_program(mode, base, pitch, height,
				4'($urandom), 4'($urandom));

			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 22) begin
					send_palette(4'($urandom), 16'($urandom));
				end else begin
					// keep most rows inside the cell, let some stray past it
					row_span = (cell_height > 32) ? 32 : cell_height;
					if (row_span != 0 && $urandom_range(0, 9) < 8)
						row = 5'($urandom_range(0, row_span - 1));
					else
						row = 5'($urandom);
					roll      = $urandom_range(0, 19);
					column    = (roll == 0) ? 8'd255 : (roll == 1) ? 8'd0 : 8'($urandom);
					roll      = $urandom_range(0, 19);
					text_line = (roll == 0) ? 8'd255 : (roll == 1) ? 8'd0 : 8'($urandom);
					send_render(16'($urandom), column, text_line, row, 8'($urandom));
				end
			end
		end

		// drop valid, wait for the last words, then give stragglers a chance
		in_chan.valid = 1'b0;
		wait (words_outstanding == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
